FILE: design/priority_round_robin_task_scheduler_top_macros.svh
// assertion macros for the task scheduler
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PRRTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
`define PRRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define PRRTS_ASSERT_NOW(label, clk, rst, ante, cons)
`define PRRTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/prrts_pkg.sv
// shared constants, codes and result type for the task scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prrts_pkg;

   localparam int TASK_SLOTS_DEF      = 16;
   localparam int PRIORITY_LEVELS_DEF = 8;

   localparam int OP_W     = 2;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
   localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADPRI   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOREADY  = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_task;
      logic                result_valid;
      logic                switch_request;
   } res_type;

endpackage

`default_nettype wire

FILE: design/prrts_if.sv
// valid/ready channel interfaces for request and response words
// depends on prrts_pkg
`timescale 1ns / 1ps
`default_nettype none

interface prrts_req_if import prrts_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] op;
   logic [ID_W-1:0] task_id;
   logic [ID_W-1:0] priority_req;
   logic            current_valid;
   logic [ID_W-1:0] current_task;
   logic            start_only;

   modport source (
      output valid, op, task_id, priority_req, current_valid, current_task, start_only,
      input  ready
   );
   modport sink (
      input  valid, op, task_id, priority_req, current_valid, current_task, start_only,
      output ready
   );
endinterface

interface prrts_rsp_if import prrts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     result_task;
   logic                result_valid;
   logic                switch_request;

   modport source (
      output valid, status, result_task, result_valid, switch_request,
      input  ready
   );
   modport sink (
      input  valid, status, result_task, result_valid, switch_request,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/prrts_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module prrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/prrts_ctrl.sv
// sequencer, slot/list state and the shared index scan unit of the scheduler
// depends on prrts_pkg, prrts_if and prrts_ram
`timescale 1ns / 1ps
`default_nettype none

module prrts_ctrl import prrts_pkg::*; #(
   parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   prrts_req_if.sink    req_ch,
   output logic         done,
   output res_type      res,
   input  wire logic    taken
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int PRI_W  = $clog2(PRIORITY_LEVELS);
   localparam int LINK_W = $clog2(TASK_SLOTS + 1);
   localparam int IDX_W  = (SLOT_W > PRI_W) ? SLOT_W : PRI_W;

   localparam logic [LINK_W-1:0] NO_SLOT   = LINK_W'(TASK_SLOTS);
   localparam logic [IDX_W-1:0]  SLOT_LAST = IDX_W'(TASK_SLOTS - 1);
   localparam logic [IDX_W-1:0]  LEVEL_TOP = IDX_W'(PRIORITY_LEVELS - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FREE  = 7'b0000010,
      S_LEVEL = 7'b0000100,
      S_LOAD  = 7'b0001000,
      S_RD    = 7'b0010000,
      S_CHK   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [TASK_SLOTS-1:0] used_ff, used_in;
   logic [LINK_W-1:0]   head_ff [PRIORITY_LEVELS];
   logic [LINK_W-1:0]   head_in [PRIORITY_LEVELS];

   logic [OP_W-1:0]     op_ff, op_in;
   logic [SLOT_W-1:0]   tid_ff, tid_in;
   logic [ID_W-1:0]     pri_ff, pri_in;
   logic                running_ff, running_in;
   logic                start_only_ff, start_only_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [LINK_W-1:0]   prev_ff, prev_in;
   logic [PRI_W-1:0]    lvl_ff, lvl_in;
   logic [SLOT_W-1:0]   fslot_ff, fslot_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   res_type             res_ff, res_in;

   logic                prio_we;
   logic [SLOT_W-1:0]   prio_waddr, prio_raddr;
   logic [PRI_W-1:0]    prio_wdata, prio_rdata;
   logic                link_we;
   logic [SLOT_W-1:0]   link_waddr, link_raddr;
   logic [LINK_W-1:0]   link_wdata, link_rdata;

   logic [SLOT_W-1:0]   req_tid_slot, req_cur_slot, idx_slot;
   logic [PRI_W-1:0]    idx_lvl, pri_lvl;
   logic                req_tid_ok, req_cur_ok, pri_ok;

   prrts_ram #(.WIDTH(PRI_W), .DEPTH(TASK_SLOTS)) u_prio_ram (
      .clock (clock),
      .we    (prio_we),
      .waddr (prio_waddr),
      .wdata (prio_wdata),
      .raddr (prio_raddr),
      .rdata (prio_rdata)
   );

   prrts_ram #(.WIDTH(LINK_W), .DEPTH(TASK_SLOTS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   assign req_tid_slot = SLOT_W'(req_ch.task_id);
   assign req_cur_slot = SLOT_W'(req_ch.current_task);
   assign req_tid_ok   = (32'(req_ch.task_id) < TASK_SLOTS) && used_ff[req_tid_slot];
   assign req_cur_ok   = req_ch.current_valid && (32'(req_ch.current_task) < TASK_SLOTS)
                         && used_ff[req_cur_slot];
   assign pri_ok       = (32'(pri_ff) < PRIORITY_LEVELS);
   assign pri_lvl      = PRI_W'(pri_ff);
   assign idx_slot     = idx_ff[SLOT_W-1:0];
   assign idx_lvl      = idx_ff[PRI_W-1:0];

   // read addresses come from the request word while idle so data is ready next cycle
   always_comb begin
      if (state_ff == S_IDLE) begin
         prio_raddr = (req_ch.op == OP_DELETE) ? req_tid_slot : req_cur_slot;
         link_raddr = req_cur_slot;
      end else begin
         prio_raddr = (op_ff == OP_DELETE) ? tid_ff : cur_ff[SLOT_W-1:0];
         link_raddr = cur_ff[SLOT_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      head_in       = head_ff;
      op_in         = op_ff;
      tid_in        = tid_ff;
      pri_in        = pri_ff;
      running_in    = running_ff;
      start_only_in = start_only_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      lvl_in        = lvl_ff;
      fslot_in      = fslot_ff;
      idx_in        = idx_ff;
      res_in        = res_ff;
      prio_we       = 1'b0;
      prio_waddr    = idx_slot;
      prio_wdata    = pri_lvl;
      link_we       = 1'b0;
      link_waddr    = idx_slot;
      link_wdata    = NO_SLOT;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.op;
               tid_in        = req_tid_slot;
               pri_in        = req_ch.priority_req;
               cur_in        = LINK_W'(req_cur_slot);
               running_in    = req_cur_ok;
               start_only_in = req_ch.start_only;
               res_in        = '0;
               res_in.status = ST_OK;
               case (req_ch.op)
                  OP_CREATE: begin
                     idx_in   = '0;
                     state_in = S_FREE;
                  end
                  OP_DELETE: begin
                     if (req_tid_ok) begin
                        state_in = S_LOAD;
                     end else begin
                        res_in.status = ST_NOTFOUND;
                        state_in      = S_DONE;
                     end
                  end
                  OP_SCHEDULE: begin
                     idx_in   = LEVEL_TOP;
                     state_in = S_LEVEL;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // lowest free slot scan
         S_FREE: begin
            if (!used_ff[idx_slot]) begin
               if (!pri_ok) begin
                  res_in.status = ST_BADPRI;
                  state_in      = S_DONE;
               end else begin
                  fslot_in            = idx_slot;
                  used_in[idx_slot]   = 1'b1;
                  prio_we             = 1'b1;
                  link_we             = 1'b1;
                  res_in.result_task  = ID_W'(idx_slot);
                  res_in.result_valid = 1'b1;
                  if (head_ff[pri_lvl] == NO_SLOT) begin
                     head_in[pri_lvl] = LINK_W'(idx_slot);
                     state_in         = S_DONE;
                  end else begin
                     cur_in   = head_ff[pri_lvl];
                     state_in = S_RD;
                  end
               end
            end else if (idx_ff == SLOT_LAST) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // highest non-empty level scan
         S_LEVEL: begin
            if (head_ff[idx_lvl] != NO_SLOT) begin
               res_in.result_valid   = 1'b1;
               res_in.switch_request = !start_only_ff;
               if (running_ff && (prio_rdata >= idx_lvl) && (link_rdata != NO_SLOT)) begin
                  res_in.result_task = ID_W'(link_rdata);
               end else begin
                  res_in.result_task = ID_W'(head_ff[idx_lvl]);
               end
               state_in = S_DONE;
            end else if (idx_ff == '0) begin
               res_in.status = ST_NOREADY;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end

         S_LOAD: begin
            lvl_in  = prio_rdata;
            prev_in = NO_SLOT;
            cur_in  = head_ff[prio_rdata];
            if (head_ff[prio_rdata] == NO_SLOT) begin
               used_in[tid_ff] = 1'b0;
               state_in        = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end

         S_RD: begin
            state_in = S_CHK;
         end

         // one list node per visit
         S_CHK: begin
            if (op_ff == OP_CREATE) begin
               if (link_rdata == NO_SLOT) begin
                  link_we    = 1'b1;
                  link_waddr = cur_ff[SLOT_W-1:0];
                  link_wdata = LINK_W'(fslot_ff);
                  state_in   = S_DONE;
               end else begin
                  cur_in   = link_rdata;
                  state_in = S_RD;
               end
            end else if (cur_ff == LINK_W'(tid_ff)) begin
               if (prev_ff == NO_SLOT) begin
                  head_in[lvl_ff] = link_rdata;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff[SLOT_W-1:0];
                  link_wdata = link_rdata;
               end
               used_in[tid_ff] = 1'b0;
               state_in        = S_DONE;
            end else if (link_rdata == NO_SLOT) begin
               used_in[tid_ff] = 1'b0;
               state_in        = S_DONE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               state_in = S_RD;
            end
         end

         S_DONE: begin
            if (taken) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         head_ff  <= '{default: NO_SLOT};
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      pri_ff        <= pri_in;
      running_ff    <= running_in;
      start_only_ff <= start_only_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      lvl_ff        <= lvl_in;
      fslot_ff      <= fslot_in;
      idx_ff        <= idx_in;
      res_ff        <= res_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign done         = (state_ff == S_DONE);
   assign res          = res_ff;

endmodule

`default_nettype wire

FILE: design/priority_round_robin_task_scheduler_top.sv
// create scans upward for the lowest free slot, then walks its non-empty list to the tail
// delete walks the task's list up to it unless missing; schedule scans the levels from the top
// one word at a time: the sequencer and its shared scan counter serve a single request
// the response register lets a new request in while a response waits to be taken
// reset: synchronous, active high; empties all lists and frees all slots
// top level of the task scheduler; depends on prrts_pkg, prrts_if, prrts_ctrl and macros
`timescale 1ns / 1ps
`default_nettype none
`include "priority_round_robin_task_scheduler_top_macros.svh"

module priority_round_robin_task_scheduler_top import prrts_pkg::*; #(
   parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   prrts_req_if.sink   req_ch,
   prrts_rsp_if.source rsp_ch
);

   logic    ctrl_done;
   logic    ctrl_taken;
   res_type ctrl_res;
   logic    rsp_valid_ff;
   res_type rsp_word_ff;

   prrts_ctrl #(
      .TASK_SLOTS      (TASK_SLOTS),
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .done   (ctrl_done),
      .res    (ctrl_res),
      .taken  (ctrl_taken)
   );

   assign ctrl_taken = ctrl_done && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_taken) begin
         rsp_word_ff <= ctrl_res;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_word_ff.status;
   assign rsp_ch.result_task    = rsp_word_ff.result_task;
   assign rsp_ch.result_valid   = rsp_word_ff.result_valid;
   assign rsp_ch.switch_request = rsp_word_ff.switch_request;

   `PRRTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `PRRTS_ASSERT_NEXT(a_done_held, clock, reset, ctrl_done && !ctrl_taken, ctrl_done)
   `PRRTS_ASSERT_NOW(a_error_no_task, clock, reset, rsp_ch.valid && (rsp_ch.status != ST_OK), !rsp_ch.result_valid)
   `PRRTS_ASSERT_NOW(a_switch_has_task, clock, reset, rsp_ch.valid && rsp_ch.switch_request, rsp_ch.result_valid)

endmodule

`default_nettype wire

FILE: verif/prrts_checker.sv
`timescale 1ns / 1ps
// scoreboard for the task scheduler: mirrors the task table, predicts every reply word
// and compares it field by field; depends on prrts_pkg and prrts_if
module prrts_checker import prrts_pkg::*; (
   input  logic clock,
   input  logic reset,
   prrts_req_if req_ch,
   prrts_rsp_if rsp_ch,
   output int   fail_count,
   output int   pending_count
);

   localparam int         NSLOT   = TASK_SLOTS_DEF;
   localparam int         NLVL    = PRIORITY_LEVELS_DEF;
   localparam logic [4:0] NO_TASK = 5'(NSLOT);

   logic       used     [NSLOT];
   logic [2:0] level_of [NSLOT];
   logic [4:0] next_of  [NSLOT];
   logic [4:0] head_of  [NLVL];
   int         live;
   res_type    reply_q[$];
   int         errs;

   function automatic void append_task(int lvl, int s);
      logic [4:0] walk;
      next_of[s] = NO_TASK;
      if (head_of[lvl] == NO_TASK) begin
         head_of[lvl] = 5'(s);
      end else begin
         walk = head_of[lvl];
         while (next_of[walk[3:0]] != NO_TASK) walk = next_of[walk[3:0]];
         next_of[walk[3:0]] = 5'(s);
      end
   endfunction

   function automatic void unlink_task(int lvl, int s);
      logic [4:0] walk;
      logic [4:0] prev;
      walk = head_of[lvl];
      prev = NO_TASK;
      while (walk != NO_TASK) begin
         if (walk == 5'(s)) begin
            if (prev == NO_TASK) head_of[lvl] = next_of[s];
            else next_of[prev[3:0]] = next_of[s];
            return;
         end
         prev = walk;
         walk = next_of[walk[3:0]];
      end
   endfunction

   // applies one request word to the mirrored table and returns its reply
   function automatic res_type run_table_op(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                                            logic [ID_W-1:0] pri, logic cur_valid,
                                            logic [ID_W-1:0] cur, logic start_only);
      res_type r;
      int      free_slot;
      int      top_lvl;
      int      i;
      r = '0;
      case (op)
         OP_CREATE: begin
            free_slot = NSLOT;
            for (i = NSLOT - 1; i >= 0; i--) if (!used[i]) free_slot = i;
            if (live >= NSLOT || free_slot == NSLOT) begin
               r.status = ST_FULL;
            end else if (pri >= NLVL) begin
               r.status = ST_BADPRI;
            end else begin
               used[free_slot]     = 1'b1;
               level_of[free_slot] = pri[2:0];
               append_task(int'(pri), free_slot);
               live++;
               r.result_task  = free_slot[3:0];
               r.result_valid = 1'b1;
            end
         end
         OP_DELETE: begin
            if (!used[tid]) begin
               r.status = ST_NOTFOUND;
            end else begin
               unlink_task(int'(level_of[tid]), int'(tid));
               used[tid]    = 1'b0;
               next_of[tid] = NO_TASK;
               live--;
            end
         end
         OP_SCHEDULE: begin
            top_lvl = NLVL;
            for (i = 0; i < NLVL; i++) if (head_of[i] != NO_TASK) top_lvl = i;
            if (top_lvl == NLVL) begin
               r.status = ST_NOREADY;
            end else begin
               r.result_task = head_of[top_lvl][3:0];
               // running task at the top level hands over to its successor
               if (cur_valid && used[cur] && level_of[cur] >= top_lvl &&
                   next_of[cur] != NO_TASK)
                  r.result_task = next_of[cur][3:0];
               r.result_valid   = 1'b1;
               r.switch_request = !start_only;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
      if (exp_v !== act_v) begin
         errs++;
         $display("%0t: reply %s expected %0d got %0d", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      res_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < NSLOT; i++) begin
            used[i]     = 1'b0;
            level_of[i] = '0;
            next_of[i]  = NO_TASK;
         end
         for (i = 0; i < NLVL; i++) head_of[i] = NO_TASK;
         live = 0;
         reply_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reply_q.size() == 0) begin
               errs++;
               $display("%0t: reply word with none expected, status %0d task %0d",
                        $time, rsp_ch.status, rsp_ch.result_task);
            end else begin
               want = reply_q.pop_front();
               check_field("status", 4'(want.status), 4'(rsp_ch.status));
               check_field("result_task", want.result_task, rsp_ch.result_task);
               check_field("result_valid", 4'(want.result_valid), 4'(rsp_ch.result_valid));
               check_field("switch_request", 4'(want.switch_request),
                           4'(rsp_ch.switch_request));
            end
         end
         if (req_ch.valid && req_ch.ready)
            reply_q.push_back(run_table_op(req_ch.op, req_ch.task_id, req_ch.priority_req,
                                           req_ch.current_valid, req_ch.current_task,
                                           req_ch.start_only));
      end
      fail_count    <= errs;
      pending_count <= reply_q.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// top of the task scheduler testbench: clock, reset, request stimulus, reply stalls, verdict
// depends on prrts_pkg, prrts_if, the scheduler top and prrts_checker
module tb;
   import prrts_pkg::*;

   localparam int              NLVL      = PRIORITY_LEVELS_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_MOSTLY} stall_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   int              fail_count;
   int              pending_count;
   int              burst_left;
   logic [ID_W-1:0] last_pick = '0;
   stall_type       stall_mode;
   int              stall_left;
   int              stall_phase;

   prrts_req_if req_ch ();
   prrts_rsp_if rsp_ch ();

   priority_round_robin_task_scheduler_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   prrts_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reply side stalls on a pattern that is drawn anew at random whenever its run ends
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode  = STALL_NONE;
         stall_left  = 0;
         stall_phase = 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            STALL_NONE:   rsp_ch.ready <= 1'b1;
            STALL_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_ch.ready <= (stall_phase % 7 == 0);
            default:      rsp_ch.ready <= (stall_phase % 4 != 0);
         endcase
      end
   end

   // remember the last chosen task so schedules can follow the round robin
   always @(posedge clock)
      if (rsp_ch.valid && rsp_ch.ready && rsp_ch.result_valid) last_pick <= rsp_ch.result_task;

   task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tid,
                            input logic [ID_W-1:0] pri, input logic cv,
                            input logic [ID_W-1:0] cur, input logic so);
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.task_id       <= tid;
      req_ch.priority_req  <= pri;
      req_ch.current_valid <= cv;
      req_ch.current_task  <= cur;
      req_ch.start_only    <= so;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic send_random(input bit filling);
      int              r;
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] pri;
      logic [ID_W-1:0] cur;
      logic            cv;
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 15)) op = OP_CREATE;
      else if (r < (filling ? 75 : 65)) op = OP_DELETE;
      else if (r < 97) op = OP_SCHEDULE;
      else op = OP_UNUSED;
      r = $urandom_range(0, 9);
      if (r == 0) pri = ID_W'($urandom_range(NLVL, 15));
      else if (r < 6) pri = ID_W'($urandom_range(NLVL - 3, NLVL - 1));
      else pri = ID_W'($urandom_range(0, NLVL - 1));
      r = $urandom_range(0, 9);
      if (r < 6) begin
         cv  = 1'b1;
         cur = last_pick;
      end else begin
         cv  = (r < 8);
         cur = ID_W'($urandom_range(0, 15));
      end
      send_word(op, ID_W'($urandom_range(0, 15)), pri, cv, cur, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int phase;
      int k;
      req_ch.valid         <= 1'b0;
      req_ch.op            <= OP_CREATE;
      req_ch.task_id       <= '0;
      req_ch.priority_req  <= '0;
      req_ch.current_valid <= 1'b0;
      req_ch.current_task  <= '0;
      req_ch.start_only    <= 1'b0;
      burst_left = 8;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd15, 1'b1);
      send_word(OP_DELETE, 4'd15, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_DELETE, 4'd0, 4'd0, 1'b0, 4'd0, 1'b0);
      // bad priorities use no slot
      send_word(OP_CREATE, 4'd0, 4'd8, 1'b0, 4'd0, 1'b0);
      send_word(OP_CREATE, 4'd15, 4'd15, 1'b1, 4'd15, 1'b1);
      // three tasks on the top level, one on the bottom
      send_word(OP_CREATE, 4'd0, 4'd7, 1'b0, 4'd0, 1'b0);
      send_word(OP_CREATE, 4'd0, 4'd7, 1'b0, 4'd0, 1'b0);
      send_word(OP_CREATE, 4'd0, 4'd7, 1'b0, 4'd0, 1'b0);
      send_word(OP_CREATE, 4'd0, 4'd0, 1'b0, 4'd0, 1'b0);
      // round robin, wrap, lower priority runner, stale runner, no runner
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd2, 1'b1);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd3, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd9, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b0, 4'd1, 1'b0);
      send_word(OP_UNUSED, 4'd15, 4'd15, 1'b1, 4'd15, 1'b1);
      // unlink head, tail, last; then the bottom level takes over
      send_word(OP_DELETE, 4'd0, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd1, 1'b0);
      send_word(OP_DELETE, 4'd2, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_DELETE, 4'd1, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd3, 1'b1);
      send_word(OP_DELETE, 4'd3, 4'd0, 1'b0, 4'd0, 1'b0);
      send_word(OP_SCHEDULE, 4'd0, 4'd0, 1'b1, 4'd3, 1'b0);
      send_word(OP_CREATE, 4'd0, 4'd3, 1'b0, 4'd0, 1'b0);
      wait_drained();

      for (phase = 0; phase < 10; phase++) begin
         for (k = 0; k < 48; k++) send_random(phase % 2 == 0);
         if (phase % 3 == 2) wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
